// ===== sv/quaternion_to_heading_top_assert.svh =====
// Assertion macros shared by the quaternion to heading RTL.
`ifndef QUATERNION_TO_HEADING_TOP_ASSERT_SVH
`define QUATERNION_TO_HEADING_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define QTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define QTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/qth_pkg.sv =====
// Types, constants and tables for the quaternion to heading pipeline.
package qth_pkg;

  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int QUAT_W    = 16;
  localparam int PROD_W    = 2 * QUAT_W;
  localparam int XY_W      = 36;   // vector width incl. CORDIC gain and pre-rotation
  localparam int Z_W       = 26;   // angle, 2^-16 degree
  localparam int H_W       = 28;   // angle plus offset
  localparam int OFF_W     = 9;
  localparam int HEAD_W    = 16;
  localparam int ANG_FRAC  = 16;
  localparam int HEAD_FRAC = 6;
  localparam int TABLE_LEN = 24;

  // atan(2^-n) in degrees, scaled by 2^16
  localparam int ATAN_TAB [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;   // input vector was (0,0): angle forced to 0
  } cordic_t;

endpackage

// ===== sv/qth_front.sv =====
// Rotation matrix terms from the quaternion and CORDIC pre-rotation, two stages.
`include "quaternion_to_heading_top_assert.svh"

module qth_front #(
  parameter int QUAT_FRAC_BITS = qth_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_real_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_i_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_j_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_k_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output qth_pkg::cordic_t                    data_o
);

  localparam int XY_W = qth_pkg::XY_W;
  localparam int Z_W  = qth_pkg::Z_W;
  localparam logic signed [XY_W-1:0] ONE =
    {{(XY_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
  localparam logic signed [Z_W-1:0] Z90 = Z_W'(90 <<< qth_pkg::ANG_FRAC);

  logic                               va_q, vb_q;
  logic                               ready_a, ready_b;
  logic signed [qth_pkg::PROD_W-1:0]  jj_d, kk_d, ij_d, rk_d;
  logic signed [qth_pkg::PROD_W-1:0]  jj_q, kk_q, ij_q, rk_q;
  logic signed [XY_W-1:0]             sq_sum, cr_sum, xr, yr;
  qth_pkg::cordic_t                   data_d, data_q;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  // stage A: products
  always_comb begin
    jj_d = quat_j_i * quat_j_i;
    kk_d = quat_k_i * quat_k_i;
    ij_d = quat_i_i * quat_j_i;
    rk_d = quat_real_i * quat_k_i;
  end

  // stage B: r11, -r21, then fold the left half plane by +-90 degrees
  always_comb begin
    sq_sum = XY_W'(jj_q) + XY_W'(kk_q);
    cr_sum = XY_W'(ij_q) + XY_W'(rk_q);
    xr     = ONE - (sq_sum <<< 1);
    yr     = -(cr_sum <<< 1);
    data_d.zero = (xr == '0) && (yr == '0);
    data_d.x    = xr;
    data_d.y    = yr;
    data_d.z    = '0;
    if (xr[XY_W-1]) begin
      if (!yr[XY_W-1]) begin
        data_d.x = yr;
        data_d.y = -xr;
        data_d.z = Z90;
      end else begin
        data_d.x = -yr;
        data_d.y = xr;
        data_d.z = -Z90;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      jj_q <= jj_d;
      kk_q <= kk_d;
      ij_q <= ij_d;
      rk_q <= rk_d;
    end
    if (ready_b && va_q) data_q <= data_d;
  end

  assign valid_o = vb_q;
  assign data_o  = data_q;

  // the fold never turns a nonzero vector into (0,0) or the reverse
  `QTH_ASSERT(zero_flag_match,
    vb_q |-> (data_q.zero == ((data_q.x == '0) && (data_q.y == '0))),
    "zero flag disagrees with vector")

endmodule

// ===== sv/qth_cordic_stage.sv =====
// One vectoring CORDIC iteration as a registered pipeline stage.
`include "quaternion_to_heading_top_assert.svh"

module qth_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  qth_pkg::cordic_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output qth_pkg::cordic_t data_o
);

  localparam int XY_W = qth_pkg::XY_W;
  localparam int Z_W  = qth_pkg::Z_W;
  localparam logic signed [Z_W-1:0] ATAN = Z_W'(qth_pkg::ATAN_TAB[STEP]);

  logic                   valid_q;
  logic signed [XY_W-1:0] dx, dy;
  qth_pkg::cordic_t       data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx          = data_i.y >>> STEP;
    dy          = data_i.x >>> STEP;
    data_d.zero = data_i.zero;
    if (!data_i.y[XY_W-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `QTH_ASSERT(stage_hold_on_stall,
    valid_q && !ready_i |=> valid_q && $stable(data_q),
    "CORDIC stage lost or changed a stalled item")

endmodule

// ===== sv/qth_wrap.sv =====
// Offset add, one wrap by a full turn toward 0..360 and scaling to 1/64 degree, two stages.
`include "quaternion_to_heading_top_assert.svh"

module qth_wrap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  qth_pkg::cordic_t                    data_i,
  input  logic signed [qth_pkg::OFF_W-1:0]    offset_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [qth_pkg::HEAD_W-1:0]   heading_o
);

  localparam int H_W   = qth_pkg::H_W;
  localparam int SHIFT = qth_pkg::ANG_FRAC - qth_pkg::HEAD_FRAC;
  localparam logic signed [H_W-1:0] DEG360  = H_W'(360 <<< qth_pkg::ANG_FRAC);
  localparam logic signed [H_W-1:0] NEG_DEG = H_W'(-(1 <<< qth_pkg::ANG_FRAC));
  localparam logic signed [H_W-1:0] ROUND   = H_W'((1 <<< SHIFT) - 1);

  logic                              va_q, vb_q;
  logic                              ready_a, ready_b;
  logic signed [H_W-1:0]             h1_d, h1_q, h2, h3, hr;
  logic signed [qth_pkg::HEAD_W-1:0] head_d, head_q;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_comb begin
    h1_d = (data_i.zero ? '0 : H_W'(data_i.z)) + (H_W'(offset_i) <<< qth_pkg::ANG_FRAC);
  end

  // whole degrees above 359 means h >= 360.0; below 0 means h <= -1.0
  always_comb begin
    h2     = (h1_q >= DEG360) ? h1_q - DEG360 : h1_q;
    h3     = (h2 <= NEG_DEG) ? h2 + DEG360 : h2;
    hr     = h3[H_W-1] ? h3 + ROUND : h3;    // truncate toward zero
    head_d = qth_pkg::HEAD_W'(hr >>> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) h1_q <= h1_d;
    if (ready_b && va_q) head_q <= head_d;
  end

  assign valid_o   = vb_q;
  assign heading_o = head_q;

  `QTH_ASSERT(wrap_in_bounds,
    va_q |-> (h3 < DEG360) && (h3 > -DEG360),
    "wrapped heading out of one turn")

endmodule

// ===== sv/quaternion_to_heading_top.sv =====
// Top level of the quaternion to compass heading pipeline.
//
// Converts an orientation quaternion (signed, QUAT_FRAC_BITS fraction bits)
// into a compass heading in 1/64 degree: yaw = atan2(-r21, r11) by a
// vectoring CORDIC, plus the whole-degree heading_offset, wrapped once by a
// full turn toward 0..360. The pipeline takes one quaternion per clock and
// holds items in place when the output is stalled. Two stages form the
// products and the matrix terms with the half-plane fold, one stage runs each
// CORDIC iteration, and two stages add the offset, wrap and scale.
// heading_offset is written via cfg_we_i and should only change while the
// pipeline is empty.
`include "quaternion_to_heading_top_assert.svh"

module quaternion_to_heading_top #(
  parameter int CORDIC_STEPS   = qth_pkg::CORDIC_STEPS_DEF,
  parameter int QUAT_FRAC_BITS = qth_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [qth_pkg::OFF_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_real_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_i_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_j_i,
  input  logic signed [qth_pkg::QUAT_W-1:0]   quat_k_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qth_pkg::HEAD_W-1:0]   heading_o
);

  logic signed [qth_pkg::OFF_W-1:0] heading_offset_q;

  logic             stg_valid [CORDIC_STEPS+1];
  logic             stg_ready [CORDIC_STEPS+1];
  qth_pkg::cordic_t stg_data  [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_offset_q <= '0;
    end else if (cfg_we_i) begin
      heading_offset_q <= cfg_wdata_i;
    end
  end

  qth_front #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .quat_real_i(quat_real_i),
    .quat_i_i   (quat_i_i),
    .quat_j_i   (quat_j_i),
    .quat_k_i   (quat_k_i),
    .valid_o    (stg_valid[0]),
    .ready_i    (stg_ready[0]),
    .data_o     (stg_data[0])
  );

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    qth_cordic_stage #(
      .STEP(s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(stg_valid[s]),
      .ready_o(stg_ready[s]),
      .data_i (stg_data[s]),
      .valid_o(stg_valid[s+1]),
      .ready_i(stg_ready[s+1]),
      .data_o (stg_data[s+1])
    );
  end

  qth_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stg_valid[CORDIC_STEPS]),
    .ready_o  (stg_ready[CORDIC_STEPS]),
    .data_i   (stg_data[CORDIC_STEPS]),
    .offset_i (heading_offset_q),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .heading_o(heading_o)
  );

  `QTH_ASSERT_ALWAYS(no_result_in_reset,
    !rst_ni |-> !out_valid_o,
    "result presented while in reset")

endmodule
